### hw/rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants
// Operation and status codes, controller states, datapath commands and the
// command/status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int FUNC_W     = 3;
  localparam int DATA_W     = 32;
  localparam int DEPTH_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  // operation codes carried by one input beat
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_NEG  = 3'd3,
    FN_DIV  = 3'd4,
    FN_MUL  = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_MULWB,
    S_DIV,
    S_DFIX,
    S_DONE
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_PUSH,
    DP_NEG,
    DP_READ,
    DP_ADDSUB,
    DP_MUL,
    DP_MUL_WB,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_WB
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t  op;
    logic    st_we;
    status_t st;
    logic    emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              lt2;
    logic              full;
    logic              top_zero;
    logic              div_last;
    logic              out_free;
  } dp_sts_t;

endpackage

### hw/rtl/rpn_stack_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_alu_top: postfix integer calculator on a bounded stack
// Push, add, subtract, negate, divide and multiply on signed 32-bit values;
// one result beat per input beat with new top, depth and status.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | in_func[2:0], in_operand[31:0] signed
//  out     | out_valid/out_stall| out_top_value[31:0] signed, out_depth[4:0],
//          |                    | out_status[1:0]
//
// One item at a time: decode handles push, negate, unused codes and flagged
// errors; add and subtract go on to execute, multiply to execute and product
// write-back, divide to execute, the one-bit-per-cycle divider loop and sign
// fix-up. The next beat is taken in the idle state after the result loads.
// Reset empties the stack at once; RAM contents are left as they are.
// A stalled result holds in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module rpn_stack_alu_top import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [DATA_W-1:0]   in_operand,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   out_top_value,
  output logic [DEPTH_W-1:0]         out_depth,
  output logic [STATUS_W-1:0]        out_status
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [DATA_W-1:0] top_value;

  // sequencer
  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stack and arithmetic
  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_operand    ($unsigned(in_operand)),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_top_value (top_value),
    .out_depth     (out_depth),
    .out_status    (out_status)
  );

  assign out_top_value = $signed(top_value);

endmodule

### hw/rtl/rpn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/rpn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ctrl: sequencing state machine
// Accepts one input beat, checks the stack conditions, steps the datapath
// through the operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.func)
          FN_ADD, FN_SUB, FN_MUL: begin
            state_nxt = sts.lt2 ? S_DONE : S_EXEC;
          end
          FN_DIV: begin
            state_nxt = (sts.lt2 || sts.top_zero) ? S_DONE : S_EXEC;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_EXEC: begin
        case (sts.func)
          FN_MUL:  state_nxt = S_MULWB;
          FN_DIV:  state_nxt = S_DIV;
          default: state_nxt = S_DONE;
        endcase
      end
      S_MULWB: state_nxt = S_DONE;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_DFIX;
      end
      S_DFIX: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.op    = DP_NONE;
    cmd.st    = ST_OK;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = DP_LOAD;
      end
      S_DECODE: begin
        cmd.st_we = 1'b1;
        case (sts.func)
          FN_PUSH: begin
            if (sts.full) cmd.st = ST_FULL;
            else          cmd.op = DP_PUSH;
          end
          FN_NEG: begin
            if (sts.empty) cmd.st = ST_UNDER;
            else           cmd.op = DP_NEG;
          end
          FN_ADD, FN_SUB, FN_MUL: begin
            if (sts.lt2) cmd.st = ST_UNDER;
            else         cmd.op = DP_READ;
          end
          FN_DIV: begin
            if (sts.lt2)           cmd.st = ST_UNDER;
            else if (sts.top_zero) cmd.st = ST_DIVZ;
            else                   cmd.op = DP_READ;
          end
          default: cmd.st = ST_OK;
        endcase
      end
      S_EXEC: begin
        case (sts.func)
          FN_MUL:  cmd.op = DP_MUL;
          FN_DIV:  cmd.op = DP_DIV_INIT;
          default: cmd.op = DP_ADDSUB;
        endcase
      end
      S_MULWB: cmd.op = DP_MUL_WB;
      S_DIV:   cmd.op = DP_DIV_STEP;
      S_DFIX:  cmd.op = DP_DIV_WB;
      S_DONE: begin
        cmd.emit = sts.out_free;
      end
      default: cmd.op = DP_NONE;
    endcase
  end

endmodule

### hw/rtl/rpn_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_dpath: stack storage and arithmetic
// Top of stack sits in a register, the entries below it in RAM. Holds the
// adder, a registered multiplier, a bit-serial divider and the output beat.
// ----------------------------------------------------------------------------
module rpn_dpath import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [DATA_W-1:0]   in_operand,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [DATA_W-1:0]   out_top_value,
  output logic [DEPTH_W-1:0]  out_depth,
  output logic [STATUS_W-1:0] out_status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [FUNC_W-1:0]    func_r;
  logic [DATA_W-1:0]    opnd_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_nxt;
  logic [DATA_W-1:0]    top_r;
  logic [DATA_W-1:0]    top_nxt;
  status_t              status_r;
  logic [DATA_W-1:0]    prod_r;
  logic [DATA_W-1:0]    dq_r;
  logic [DATA_W-1:0]    dq_nxt;
  logic [DATA_W-1:0]    drem_r;
  logic [DATA_W-1:0]    drem_nxt;
  logic [DATA_W-1:0]    dden_r;
  logic                 dneg_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_top_r;
  logic [DEPTH_W-1:0]   out_depth_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         cnt_m2;
  logic [DATA_W-1:0]     second;
  logic                  ram_we;
  logic                  ram_re;
  logic [DATA_W:0]       trial;
  logic [DATA_W:0]       shifted;
  logic [CW+DEPTH_W-1:0] depth_ext;
  logic [DATA_W-1:0]     top_view;

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);

  // stack entries below the top
  assign ram_we = (cmd.op == DP_PUSH) && (cnt_r != '0);
  assign ram_re = (cmd.op == DP_READ);

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (top_r),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (second)
  );

  // status towards the controller
  assign sts.func     = func_r;
  assign sts.empty    = (cnt_r == '0);
  assign sts.lt2      = (cnt_r < CW'(2));
  assign sts.full     = (cnt_r == CW'(STACK_DEPTH));
  assign sts.top_zero = (top_r == '0);
  assign sts.div_last = (dcnt_r == DIV_LAST);
  assign sts.out_free = !out_valid_r || !out_stall;

  // one divider step: shift in the next dividend bit, subtract if it fits
  assign shifted  = {drem_r, dq_r[DATA_W-1]};
  assign trial    = shifted - {1'b0, dden_r};
  assign drem_nxt = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
  assign dq_nxt   = {dq_r[DATA_W-2:0], !trial[DATA_W]};

  // stack top and depth
  always_comb begin
    top_nxt = top_r;
    cnt_nxt = cnt_r;
    unique case (cmd.op)
      DP_PUSH: begin
        top_nxt = opnd_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      DP_NEG: top_nxt = '0 - top_r;
      DP_ADDSUB: begin
        top_nxt = (func_r == FN_SUB) ? (second - top_r) : (second + top_r);
        cnt_nxt = cnt_m1;
      end
      DP_MUL_WB: begin
        top_nxt = prod_r;
        cnt_nxt = cnt_m1;
      end
      DP_DIV_WB: begin
        top_nxt = dneg_r ? ('0 - dq_r) : dq_r;
        cnt_nxt = cnt_m1;
      end
      default: begin
        top_nxt = top_r;
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      func_r <= in_func;
      opnd_r <= in_operand;
    end
  end

  // hold the status of the current item
  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      status_r <= cmd.st;
    end
  end

  // registered product, low word only
  always_ff @(posedge clk) begin
    if (cmd.op == DP_MUL) begin
      prod_r <= second * top_r;
    end
  end

  // divider on magnitudes, sign applied at write-back
  always_ff @(posedge clk) begin
    if (cmd.op == DP_DIV_INIT) begin
      dq_r   <= second[DATA_W-1] ? ('0 - second) : second;
      dden_r <= top_r[DATA_W-1] ? ('0 - top_r) : top_r;
      drem_r <= '0;
      dneg_r <= second[DATA_W-1] ^ top_r[DATA_W-1];
      dcnt_r <= '0;
    end else if (cmd.op == DP_DIV_STEP) begin
      dq_r   <= dq_nxt;
      drem_r <= drem_nxt;
      dcnt_r <= dcnt_r + DIV_CNT_W'(1);
    end
  end

  // result fields
  assign depth_ext = {DEPTH_W'(0), cnt_r};
  assign top_view  = (cnt_r != '0) ? top_r : '0;

  // output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_top_r    <= top_view;
      out_depth_r  <= depth_ext[DEPTH_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_status_r;

endmodule
